// ----- design/lbfv_pkg.sv -----
// ----------------------------------------------------------------------------
// Lorentz boost package
// Shared widths, the item record that rides along the pipeline, and the
// saturation helper for the Q16.16 results.
// ----------------------------------------------------------------------------
package lbfv_pkg;

  // Bits of the square root of 1 - beta^2 (Q.30).
  localparam int ROOT_W = 31;
  // Bits of the gamma quotient (Q.32, at most 2^62).
  localparam int GAM_W  = 63;
  // Bits of the quotient 2^64 / (gamma + 1).
  localparam int KQ_W   = 32;
  // Bits of the radicand 1 - beta^2 (Q.60).
  localparam int RAD_W  = 61;

  typedef struct packed {
    logic signed [30:0] beta_x;
    logic signed [30:0] beta_y;
    logic signed [30:0] beta_z;
    logic signed [31:0] energy;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic signed [63:0] bdotp;
    logic               bad;
  } carry_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  // Clamps a wide signed value to the 32-bit range and flags the clamp.
  function automatic sat_t sat32(input logic signed [127:0] a);
    sat_t r;
    r.ovf = !((&a[127:31]) || !(|a[127:31]));
    if (!r.ovf) begin
      r.val = a[31:0];
    end else if (a[127]) begin
      r.val = 32'h8000_0000;
    end else begin
      r.val = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

// ----- design/lorentz_boost_four_vector_top.sv -----
// Throughput: one beat per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Most of the pipeline is the square root (31 stages) and the two long
// divisions (63 and 32 stages), one result bit per stage.
// Reset clears every stage valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// Lorentz boost top level
// Boosts one four-momentum by a general velocity per beat, fully pipelined.
// ----------------------------------------------------------------------------
module lorentz_boost_four_vector_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [30:0] beta_x_i,
  input  logic signed [30:0] beta_y_i,
  input  logic signed [30:0] beta_z_i,
  input  logic signed [31:0] energy_in_i,
  input  logic signed [31:0] mom_x_in_i,
  input  logic signed [31:0] mom_y_in_i,
  input  logic signed [31:0] mom_z_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] energy_out_o,
  output logic signed [31:0] mom_x_out_o,
  output logic signed [31:0] mom_y_out_o,
  output logic signed [31:0] mom_z_out_o,
  output logic               bad_boost_o,
  output logic               overflowed_o
);

  logic adv;
  logic ov_q;

  assign adv        = !ov_q || out_ready_i;
  assign in_ready_o = adv;

  // --------------------------------------------------------------------------
  // Stage 1: squares of beta and the beta.p products.
  // --------------------------------------------------------------------------
  logic               v1_q;
  lbfv_pkg::carry_t   c1_q;
  logic signed [61:0] sqx_full, sqy_full, sqz_full;
  logic signed [62:0] bpx_d, bpy_d, bpz_d;
  logic [60:0]        sqx_q, sqy_q, sqz_q;
  logic signed [62:0] bpx_q, bpy_q, bpz_q;

  assign sqx_full = 62'(beta_x_i) * 62'(beta_x_i);
  assign sqy_full = 62'(beta_y_i) * 62'(beta_y_i);
  assign sqz_full = 62'(beta_z_i) * 62'(beta_z_i);
  assign bpx_d    = 63'(beta_x_i) * 63'(mom_x_in_i);
  assign bpy_d    = 63'(beta_y_i) * 63'(mom_y_in_i);
  assign bpz_d    = 63'(beta_z_i) * 63'(mom_z_in_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q.beta_x <= beta_x_i;
      c1_q.beta_y <= beta_y_i;
      c1_q.beta_z <= beta_z_i;
      c1_q.energy <= energy_in_i;
      c1_q.mom_x  <= mom_x_in_i;
      c1_q.mom_y  <= mom_y_in_i;
      c1_q.mom_z  <= mom_z_in_i;
      c1_q.bdotp  <= '0;
      c1_q.bad    <= 1'b0;
      sqx_q       <= sqx_full[60:0];
      sqy_q       <= sqy_full[60:0];
      sqz_q       <= sqz_full[60:0];
      bpx_q       <= bpx_d;
      bpy_q       <= bpy_d;
      bpz_q       <= bpz_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: beta^2, the bad-boost test, the radicand and beta.p.
  // --------------------------------------------------------------------------
  logic                                v2_q;
  lbfv_pkg::carry_t                    c2_q, c2_d;
  logic [lbfv_pkg::RAD_W-1:0]          d2_q, d2_d;
  logic [62:0]                         b2;
  logic [62:0]                         rad_full;
  logic                                bad2;

  assign b2       = {2'b0, sqx_q} + {2'b0, sqy_q} + {2'b0, sqz_q};
  assign bad2     = b2 >= (63'd1 << 60);
  assign rad_full = (63'd1 << 60) - b2;
  // A bad boost gets a radicand of one so the later units see clean numbers.
  assign d2_d     = bad2 ? (61'd1 << 60) : rad_full[lbfv_pkg::RAD_W-1:0];

  always_comb begin
    c2_d       = c1_q;
    c2_d.bad   = bad2;
    c2_d.bdotp = 64'(bpx_q) + 64'(bpy_q) + 64'(bpz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_q <= c2_d;
      d2_q <= d2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Square root, one root bit per stage, MSB first.
  // --------------------------------------------------------------------------
  logic                       sv_q    [lbfv_pkg::ROOT_W];
  lbfv_pkg::carry_t           sc_q    [lbfv_pkg::ROOT_W];
  logic [lbfv_pkg::RAD_W-1:0] srem_q  [lbfv_pkg::ROOT_W];
  logic [30:0]                sroot_q [lbfv_pkg::ROOT_W];

  for (genvar g = 0; g < lbfv_pkg::ROOT_W; g++) begin : g_sqrt
    localparam int I = lbfv_pkg::ROOT_W - 1 - g;
    logic                       i_v;
    lbfv_pkg::carry_t           i_c;
    logic [lbfv_pkg::RAD_W-1:0] i_rem;
    logic [30:0]                i_root;
    logic [62:0]                trial;
    logic [62:0]                rdiff;
    logic                       take;

    if (g == 0) begin : g_first
      assign i_v    = v2_q;
      assign i_c    = c2_q;
      assign i_rem  = d2_q;
      assign i_root = '0;
    end else begin : g_next
      assign i_v    = sv_q[g-1];
      assign i_c    = sc_q[g-1];
      assign i_rem  = srem_q[g-1];
      assign i_root = sroot_q[g-1];
    end

    // Growing the root by 2^I raises its square by 2^(I+1)*root + 4^I.
    assign trial = ({32'd0, i_root} << (I + 1)) + (63'd1 << (2 * I));
    assign rdiff = {2'b0, i_rem} - trial;
    assign take  = {2'b0, i_rem} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[g] <= 1'b0;
      end else if (adv) begin
        sv_q[g] <= i_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sc_q[g]    <= i_c;
        srem_q[g]  <= take ? rdiff[lbfv_pkg::RAD_W-1:0] : i_rem;
        sroot_q[g] <= take ? (i_root | (31'd1 << I)) : i_root;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Gamma = 2^62 / root, restoring division, one quotient bit per stage.
  // --------------------------------------------------------------------------
  logic                       dv_q   [lbfv_pkg::GAM_W];
  lbfv_pkg::carry_t           dc_q   [lbfv_pkg::GAM_W];
  logic [30:0]                drem_q [lbfv_pkg::GAM_W];
  logic [30:0]                dr_q   [lbfv_pkg::GAM_W];
  logic [lbfv_pkg::GAM_W-1:0] dq_q   [lbfv_pkg::GAM_W];

  for (genvar g = 0; g < lbfv_pkg::GAM_W; g++) begin : g_div_gam
    localparam int J = lbfv_pkg::GAM_W - 1 - g;
    logic                       i_v;
    lbfv_pkg::carry_t           i_c;
    logic [30:0]                i_rem;
    logic [30:0]                i_r;
    logic [lbfv_pkg::GAM_W-1:0] i_q;
    logic [31:0]                rem2;
    logic [31:0]                rdiff;
    logic                       take;

    if (g == 0) begin : g_first
      assign i_v   = sv_q[lbfv_pkg::ROOT_W-1];
      assign i_c   = sc_q[lbfv_pkg::ROOT_W-1];
      assign i_rem = '0;
      assign i_r   = sroot_q[lbfv_pkg::ROOT_W-1];
      assign i_q   = '0;
    end else begin : g_next
      assign i_v   = dv_q[g-1];
      assign i_c   = dc_q[g-1];
      assign i_rem = drem_q[g-1];
      assign i_r   = dr_q[g-1];
      assign i_q   = dq_q[g-1];
    end

    // The dividend 2^62 has a single one, which enters in the first stage.
    assign rem2  = {i_rem, (g == 0) ? 1'b1 : 1'b0};
    assign rdiff = rem2 - {1'b0, i_r};
    assign take  = rem2 >= {1'b0, i_r};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[g] <= 1'b0;
      end else if (adv) begin
        dv_q[g] <= i_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dc_q[g]   <= i_c;
        dr_q[g]   <= i_r;
        drem_q[g] <= take ? rdiff[30:0] : rem2[30:0];
        dq_q[g]   <= i_q | (63'(take) << J);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divisor gamma + 1 for the second division.
  // --------------------------------------------------------------------------
  logic             xv_q;
  lbfv_pkg::carry_t xc_q;
  logic [62:0]      xx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xv_q <= 1'b0;
    end else if (adv) begin
      xv_q <= dv_q[lbfv_pkg::GAM_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xc_q <= dc_q[lbfv_pkg::GAM_W-1];
      xx_q <= dq_q[lbfv_pkg::GAM_W-1] + (63'd1 << 32);
    end
  end

  // --------------------------------------------------------------------------
  // 2^64 / (gamma + 1). The divisor is at least 2^33, so only the low 32
  // quotient bits can be set and the division starts with a remainder of 2^32.
  // --------------------------------------------------------------------------
  logic                      qv_q   [lbfv_pkg::KQ_W];
  lbfv_pkg::carry_t          qc_q   [lbfv_pkg::KQ_W];
  logic [62:0]               qrem_q [lbfv_pkg::KQ_W];
  logic [62:0]               qx_q   [lbfv_pkg::KQ_W];
  logic [lbfv_pkg::KQ_W-1:0] qq_q   [lbfv_pkg::KQ_W];

  for (genvar g = 0; g < lbfv_pkg::KQ_W; g++) begin : g_div_k
    localparam int J = lbfv_pkg::KQ_W - 1 - g;
    logic                      i_v;
    lbfv_pkg::carry_t          i_c;
    logic [62:0]               i_rem;
    logic [62:0]               i_x;
    logic [lbfv_pkg::KQ_W-1:0] i_q;
    logic [63:0]               rem2;
    logic [63:0]               rdiff;
    logic                      take;

    if (g == 0) begin : g_first
      assign i_v   = xv_q;
      assign i_c   = xc_q;
      assign i_rem = 63'd1 << 32;
      assign i_x   = xx_q;
      assign i_q   = '0;
    end else begin : g_next
      assign i_v   = qv_q[g-1];
      assign i_c   = qc_q[g-1];
      assign i_rem = qrem_q[g-1];
      assign i_x   = qx_q[g-1];
      assign i_q   = qq_q[g-1];
    end

    assign rem2  = {i_rem, 1'b0};
    assign rdiff = rem2 - {1'b0, i_x};
    assign take  = rem2 >= {1'b0, i_x};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        qv_q[g] <= 1'b0;
      end else if (adv) begin
        qv_q[g] <= i_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        qc_q[g]   <= i_c;
        qx_q[g]   <= i_x;
        qrem_q[g] <= take ? rdiff[62:0] : rem2[62:0];
        qq_q[g]   <= i_q | (32'(take) << J);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage K: gamma, k = gamma - 1 + 1/(gamma + 1), and u = E*2^30 - beta.p.
  // --------------------------------------------------------------------------
  logic               kv_q;
  lbfv_pkg::carry_t   kc_q, kc_in;
  logic [62:0]        kg_q, kk_q, kx_in;
  logic [31:0]        kq_in;
  logic signed [64:0] ku_q, e30;

  assign kc_in = qc_q[lbfv_pkg::KQ_W-1];
  assign kx_in = qx_q[lbfv_pkg::KQ_W-1];
  assign kq_in = qq_q[lbfv_pkg::KQ_W-1];
  assign e30   = {{3{kc_in.energy[31]}}, kc_in.energy, 30'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kv_q <= 1'b0;
    end else if (adv) begin
      kv_q <= qv_q[lbfv_pkg::KQ_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kc_q <= kc_in;
      kg_q <= kx_in - (63'd1 << 32);
      kk_q <= kx_in - (63'd1 << 33) + {31'd0, kq_in};
      ku_q <= e30 - 65'(kc_in.bdotp);
    end
  end

  // --------------------------------------------------------------------------
  // M1: 33x33 partial products of gamma*u, k*bp and gamma*E.
  // --------------------------------------------------------------------------
  logic signed [32:0] gl [2];
  logic signed [32:0] kl [2];
  logic signed [32:0] ul [3];
  logic signed [32:0] bl [2];
  logic signed [32:0] el;

  assign gl[0] = $signed({1'b0, kg_q[31:0]});
  assign gl[1] = $signed({2'b0, kg_q[62:32]});
  assign kl[0] = $signed({1'b0, kk_q[31:0]});
  assign kl[1] = $signed({2'b0, kk_q[62:32]});
  assign ul[0] = $signed({1'b0, ku_q[31:0]});
  assign ul[1] = $signed({1'b0, ku_q[63:32]});
  assign ul[2] = $signed({33{ku_q[64]}});
  assign bl[0] = $signed({1'b0, kc_q.bdotp[31:0]});
  assign bl[1] = $signed({kc_q.bdotp[63], kc_q.bdotp[63:32]});
  assign el    = $signed({kc_q.energy[31], kc_q.energy});

  logic               m1v_q;
  lbfv_pkg::carry_t   m1c_q;
  logic signed [65:0] pgu_q [2][3];
  logic signed [65:0] pkb_q [2][2];
  logic signed [65:0] pge_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1v_q <= 1'b0;
    end else if (adv) begin
      m1v_q <= kv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1c_q <= kc_q;
      for (int a = 0; a < 2; a++) begin
        for (int b = 0; b < 3; b++) begin
          pgu_q[a][b] <= 66'(gl[a]) * 66'(ul[b]);
        end
        for (int b = 0; b < 2; b++) begin
          pkb_q[a][b] <= 66'(kl[a]) * 66'(bl[b]);
        end
        pge_q[a] <= 66'(gl[a]) * 66'(el);
      end
    end
  end

  // --------------------------------------------------------------------------
  // M2: partial products summed into full-width signed products.
  // --------------------------------------------------------------------------
  logic                m2v_q;
  lbfv_pkg::carry_t    m2c_q;
  logic signed [127:0] gu_q, kbp_q, ge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2v_q <= 1'b0;
    end else if (adv) begin
      m2v_q <= m1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2c_q <= m1c_q;
      gu_q  <= 128'(pgu_q[0][0])
             + ((128'(pgu_q[0][1]) + 128'(pgu_q[1][0])) <<< 32)
             + ((128'(pgu_q[0][2]) + 128'(pgu_q[1][1])) <<< 64)
             + (128'(pgu_q[1][2]) <<< 96);
      kbp_q <= 128'(pkb_q[0][0])
             + ((128'(pkb_q[0][1]) + 128'(pkb_q[1][0])) <<< 32)
             + (128'(pkb_q[1][1]) <<< 64);
      ge_q  <= 128'(pge_q[0]) + (128'(pge_q[1]) <<< 32);
    end
  end

  // --------------------------------------------------------------------------
  // M3: w = floor((k*bp - gamma*E*2^30) / 2^32) and the boosted energy.
  // --------------------------------------------------------------------------
  logic                m3v_q;
  lbfv_pkg::carry_t    m3c_q;
  logic signed [127:0] wdiff, eround;
  logic signed [95:0]  w_q;
  lbfv_pkg::sat_t      eo_m3_q;

  assign wdiff  = kbp_q - (ge_q <<< 30);
  assign eround = (gu_q + (128'sd1 <<< 61)) >>> 62;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3v_q <= 1'b0;
    end else if (adv) begin
      m3v_q <= m2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m3c_q   <= m2c_q;
      w_q     <= wdiff[127:32];
      eo_m3_q <= lbfv_pkg::sat32(eround);
    end
  end

  // --------------------------------------------------------------------------
  // M4: partial products of beta_i * w.
  // --------------------------------------------------------------------------
  logic signed [32:0] wl [3];
  logic signed [32:0] bel [3];

  assign wl[0]  = $signed({1'b0, w_q[31:0]});
  assign wl[1]  = $signed({1'b0, w_q[63:32]});
  assign wl[2]  = $signed({w_q[95], w_q[95:64]});
  assign bel[0] = $signed({{2{m3c_q.beta_x[30]}}, m3c_q.beta_x});
  assign bel[1] = $signed({{2{m3c_q.beta_y[30]}}, m3c_q.beta_y});
  assign bel[2] = $signed({{2{m3c_q.beta_z[30]}}, m3c_q.beta_z});

  logic               m4v_q;
  lbfv_pkg::carry_t   m4c_q;
  logic signed [65:0] pbw_q [3][3];
  lbfv_pkg::sat_t     eo_m4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m4v_q <= 1'b0;
    end else if (adv) begin
      m4v_q <= m3v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m4c_q   <= m3c_q;
      eo_m4_q <= eo_m3_q;
      for (int c = 0; c < 3; c++) begin
        for (int b = 0; b < 3; b++) begin
          pbw_q[c][b] <= 66'(bel[c]) * 66'(wl[b]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // M5: p_i' = round((p_i*2^60 + beta_i*w) / 2^60), saturation, output beat.
  // --------------------------------------------------------------------------
  logic signed [31:0]  pin [3];
  logic signed [127:0] psum [3];
  lbfv_pkg::sat_t      psat [3];

  assign pin[0] = m4c_q.mom_x;
  assign pin[1] = m4c_q.mom_y;
  assign pin[2] = m4c_q.mom_z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      psum[c] = ((128'(pin[c]) <<< 60) + 128'(pbw_q[c][0])
                + (128'(pbw_q[c][1]) <<< 32) + (128'(pbw_q[c][2]) <<< 64)
                + (128'sd1 <<< 59)) >>> 60;
      psat[c] = lbfv_pkg::sat32(psum[c]);
    end
  end

  logic signed [31:0] eo_q, mx_q, my_q, mz_q;
  logic               bad_q, ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= m4v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bad_q <= m4c_q.bad;
      if (m4c_q.bad) begin
        // Velocity at or above light speed: the item passes through.
        eo_q  <= m4c_q.energy;
        mx_q  <= m4c_q.mom_x;
        my_q  <= m4c_q.mom_y;
        mz_q  <= m4c_q.mom_z;
        ovf_q <= 1'b0;
      end else begin
        eo_q  <= eo_m4_q.val;
        mx_q  <= psat[0].val;
        my_q  <= psat[1].val;
        mz_q  <= psat[2].val;
        ovf_q <= eo_m4_q.ovf | psat[0].ovf | psat[1].ovf | psat[2].ovf;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign energy_out_o = eo_q;
  assign mom_x_out_o  = mx_q;
  assign mom_y_out_o  = my_q;
  assign mom_z_out_o  = mz_q;
  assign bad_boost_o  = bad_q;
  assign overflowed_o = ovf_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The root never exceeds 2^30, so gamma is at least one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[lbfv_pkg::GAM_W-1] |-> (dq_q[lbfv_pkg::GAM_W-1] >= (63'd1 << 32)))
    else $error("gamma below one");

  // The divisor gamma + 1 is at least two, so 1/(gamma + 1) is at most one half.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qv_q[lbfv_pkg::KQ_W-1] |-> (qq_q[lbfv_pkg::KQ_W-1] <= (32'd1 << 31)))
    else $error("k quotient out of range");

  // A pass-through beat never reports saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_boost_o) |-> !overflowed_o)
    else $error("overflow flagged on a bad boost");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lorentz boost testbench
// Drives velocity and four-momentum beats with bursty traffic and a stalling
// receiver, predicts each boosted four-vector in wide fixed point or reads it
// from a typed row, and checks every output beat field by field in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_RANDOM = 1200;
  localparam int NUM_DIRECTED = 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic signed [30:0] bx, by, bz;
    logic signed [31:0] e, px, py, pz;
  } boost_in_t;

  typedef struct packed {
    logic signed [31:0] e, px, py, pz;
    logic bad, ovf;
  } boost_out_t;

  typedef struct packed {
    boost_in_t  stim;
    logic       typed;
    boost_out_t res;
  } vec_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [30:0] beta_x_i = '0, beta_y_i = '0, beta_z_i = '0;
  logic signed [31:0] energy_in_i = '0, mom_x_in_i = '0, mom_y_in_i = '0;
  logic signed [31:0] mom_z_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] energy_out_o, mom_x_out_o, mom_y_out_o, mom_z_out_o;
  logic bad_boost_o, overflowed_o;

  boost_out_t boosted_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  vec_row_t vec_rows[NUM_DIRECTED];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lorentz_boost_four_vector_top dut (.*);

  function automatic logic [31:0] clamp32(input logic signed [127:0] a,
                                          inout logic ovf);
    if (a > 128'sh7fff_ffff) begin
      ovf = 1'b1;
      return 32'h7fff_ffff;
    end
    if (a < -128'sh8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return a[31:0];
  endfunction

  // Integer square root by bit-pair restoring, floor result.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic boost_out_t boost_four_vector(input boost_in_t s);
    boost_out_t o;
    logic signed [127:0] b[3], p[3], e, b2, bp, u, w, t, g, kk;
    logic [63:0] d, rt, gq, q;
    logic ovf;
    b[0] = 128'(s.bx); b[1] = 128'(s.by); b[2] = 128'(s.bz);
    p[0] = 128'(s.px); p[1] = 128'(s.py); p[2] = 128'(s.pz);
    e = 128'(s.e);
    b2 = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
    o.bad = 1'b0;
    o.ovf = 1'b0;
    if (b2 >= (128'sd1 <<< 60)) begin
      o.e = s.e; o.px = s.px; o.py = s.py; o.pz = s.pz;
      o.bad = 1'b1;
      return o;
    end
    d = (64'd1 << 60) - b2[63:0];
    rt = floor_sqrt(d);
    gq = (64'd1 << 62) / rt;
    q = 64'((128'd1 << 64) / ({64'd0, gq} + (128'd1 << 32)));
    g = $signed({64'd0, gq});
    kk = g - (128'sd1 <<< 32) + $signed({64'd0, q});
    bp = b[0] * p[0] + b[1] * p[1] + b[2] * p[2];
    u = (e <<< 30) - bp;
    ovf = 1'b0;
    o.e = clamp32((g * u + (128'sd1 <<< 61)) >>> 62, ovf);
    w = (kk * bp - g * (e <<< 30)) >>> 32;
    t = ((p[0] <<< 60) + b[0] * w + (128'sd1 <<< 59)) >>> 60;
    o.px = clamp32(t, ovf);
    t = ((p[1] <<< 60) + b[1] * w + (128'sd1 <<< 59)) >>> 60;
    o.py = clamp32(t, ovf);
    t = ((p[2] <<< 60) + b[2] * w + (128'sd1 <<< 59)) >>> 60;
    o.pz = clamp32(t, ovf);
    o.ovf = ovf;
    return o;
  endfunction

  function automatic logic signed [30:0] rand_beta(input int mode);
    case (mode)
      0: return $signed(31'($urandom));
      1: return $signed(31'($urandom_range(0, 1 << 20))) - 31'sd524288;
      default: return $signed(31'($urandom)) >>> $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_q16(input int mode);
    case (mode)
      0: return $signed(32'($urandom));
      default: return $signed(32'($urandom)) >>> $urandom_range(4, 20);
    endcase
  endfunction

  task automatic send_beat(input boost_in_t s);
    beta_x_i <= s.bx; beta_y_i <= s.by; beta_z_i <= s.bz;
    energy_in_i <= s.e; mom_x_in_i <= s.px; mom_y_in_i <= s.py;
    mom_z_in_i <= s.pz;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    boost_in_t s;
    boost_out_t r;
    int burst, mode;
    logic signed [30:0] bmax, bmin;
    bmax = 31'sh3fff_ffff;
    bmin = -31'sh4000_0000;
    // Zero velocity: passes through.
    vec_rows[0] = '{'{0, 0, 0, 32'sh0001_0000, 32'sh7fff_ffff, -32'sh8000_0000, 5},
                    1'b1, '{32'sh0001_0000, 32'sh7fff_ffff, -32'sh8000_0000, 5, 0, 0}};
    // Speed of light along x: flagged, passes through.
    vec_rows[1] = '{'{bmin, 0, 0, 32'sh1234_5678, -1, 7, 9}, 1'b1,
                    '{32'sh1234_5678, -1, 7, 9, 1, 0}};
    vec_rows[2] = '{'{bmax, bmax, bmax, -32'sh8000_0000, 1, 2, 3}, 1'b1,
                    '{-32'sh8000_0000, 1, 2, 3, 1, 0}};
    vec_rows[3] = '{'{bmin, bmin, bmin, 32'sh7fff_ffff, 0, 0, 0}, 1'b1,
                    '{32'sh7fff_ffff, 0, 0, 0, 1, 0}};
    vec_rows[4] = '{'{bmax, 0, 0, 32'sh0001_0000, 0, 0, 0}, 1'b0, '{default: 0}};
    vec_rows[5] = '{'{0, bmax, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0}, 1'b0,
                    '{default: 0}};
    vec_rows[6] = '{'{0, 0, bmax, -32'sh8000_0000, 0, 0, -32'sh8000_0000}, 1'b0,
                    '{default: 0}};
    vec_rows[7] = '{'{31'sh2000_0000, -31'sh2000_0000, 31'sh1000_0000,
                      32'sh0010_0000, 32'sh0008_0000, -32'sh0004_0000, 32'sh0001_0000},
                    1'b0, '{default: 0}};
    vec_rows[8] = '{'{1, -1, 0, 0, 0, 0, 0}, 1'b0, '{default: 0}};
    vec_rows[9] = '{'{-31'sh2000_0000, 0, 0, -32'sh7000_0000, 32'sh7000_0000, 0, 0},
                    1'b0, '{default: 0}};
    vec_rows[10] = '{'{31'sh2d41_3ccc, 31'sh2d41_3ccc, 0, 0, 0, 0, 0}, 1'b0,
                     '{default: 0}};
    vec_rows[11] = '{'{31'sh0000_0001, 0, 0, -1, -1, -1, -1}, 1'b0, '{default: 0}};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vec_rows[i]) begin
      r = vec_rows[i].typed ? vec_rows[i].res : boost_four_vector(vec_rows[i].stim);
      boosted_q.push_back(r);
      send_beat(vec_rows[i].stim);
      idle_gap();
    end

    for (int n = 0; n < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++) begin
        mode = $urandom_range(0, 2);
        s.bx = rand_beta(mode); s.by = rand_beta(mode); s.bz = rand_beta(mode);
        mode = $urandom_range(0, 1);
        s.e = rand_q16(mode); s.px = rand_q16(mode); s.py = rand_q16(mode);
        s.pz = rand_q16(mode);
        boosted_q.push_back(boost_four_vector(s));
        send_beat(s);
      end
      idle_gap();
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stalls in runs, with stretches of steady acceptance.
  int stall_run = 0;
  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_run <= $urandom_range(0, 8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    boost_out_t x, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{energy_out_o, mom_x_out_o, mom_y_out_o, mom_z_out_o,
              bad_boost_o, overflowed_o};
      if (boosted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Output beat with nothing expected");
      end else begin
        x = boosted_q.pop_front();
        if (got != x) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: exp E %h px %h py %h pz %h bad %b ovf %b,",
                      " got E %h px %h py %h pz %h bad %b ovf %b"},
                     x.e, x.px, x.py, x.pz, x.bad, x.ovf,
                     got.e, got.px, got.py, got.pz, got.bad, got.ovf);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (stim_done);
    wait (boosted_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
